// File: rtl/assr_pkg.sv
`default_nettype none
package assr_pkg;

    localparam logic [7:0] START_BYTE   = 8'h41;
    localparam logic [7:0] FILL_BYTE    = 8'hFF;
    localparam logic [7:0] CMD_ECHO     = 8'd0;
    localparam logic [7:0] CMD_SET_ID   = 8'd254;
    localparam logic [7:0] BROADCAST_ID = 8'd255;

    localparam logic REG_INITIAL_ID = 1'b0;
    localparam logic REG_RS485_DIR  = 1'b1;

    localparam logic [2:0] PARSE_HUNT  = 3'd0;
    localparam logic [2:0] PARSE_CHECK = 3'd5;

    localparam logic [2:0] BEAT_LAST = 3'd7;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic        mode;
        logic [7:0]  rx_byte;
        logic        handler_accept;
        logic [15:0] handler_data;
    } t_in;

    typedef struct packed {
        logic        kind;
        logic [7:0]  tx_byte;
        logic        driver_enable;
        logic        last;
        logic [7:0]  request_cmd;
        logic [15:0] request_data;
    } t_out;

    // One unit of work for the back end: a handler request or an 8-byte reply.
    typedef struct packed {
        logic        is_request;
        logic [7:0]  id;
        logic [7:0]  cmd;
        logic [15:0] data;
    } t_job;

endpackage
`default_nettype wire

// File: rtl/assr_front.sv
`default_nettype none
module assr_front
    import assr_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire t_in        i_in_data,
    input  wire logic       i_cfg_wr_en,
    input  wire logic       i_cfg_index,
    input  wire logic [7:0] i_cfg_wdata,
    input  wire logic       i_q_full,
    output logic            o_q_push,
    output t_job            o_q_job
);

    logic [2:0]  r_parse_count;
    logic [7:0]  r_frame [4];
    logic [7:0]  r_sum;
    logic [7:0]  r_current_id;
    logic        r_awaiting;
    logic [7:0]  r_pending_cmd;
    logic        r_pending_bcast;

    logic        accept;
    logic [1:0]  frame_idx;
    logic [15:0] frame_data;
    logic        frame_ok;
    logic        bcast;

    assign o_in_ready = !i_q_full;
    assign accept     = i_in_valid && o_in_ready;
    assign frame_idx  = 2'(r_parse_count - 3'd1);
    assign frame_data = {r_frame[3], r_frame[2]};
    assign bcast      = (r_frame[0] == BROADCAST_ID);
    // Frame completes with a good sum, addressed to us, and nothing is pending.
    assign frame_ok   = (i_in_data.rx_byte == r_sum) && !r_awaiting
                        && (bcast || (r_frame[0] == r_current_id));

    always_comb begin
        o_q_push = 1'b0;
        o_q_job  = '{is_request: 1'b0, id: r_current_id, cmd: r_frame[1],
                     data: frame_data};
        if (accept) begin
            if (i_in_data.mode) begin
                o_q_job.cmd  = r_pending_cmd;
                o_q_job.data = i_in_data.handler_data;
                o_q_push     = r_awaiting && i_in_data.handler_accept && !r_pending_bcast;
            end else if (r_parse_count == PARSE_CHECK && frame_ok) begin
                if (r_frame[1] == CMD_ECHO) begin
                    o_q_push = !bcast;
                end else if (r_frame[1] == CMD_SET_ID) begin
                    // The reply already carries the new id.
                    o_q_job.id = r_frame[2];
                    o_q_push   = !bcast;
                end else begin
                    o_q_job.is_request = 1'b1;
                    o_q_push           = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_parse_count   <= PARSE_HUNT;
            r_sum           <= '0;
            r_current_id    <= '0;
            r_awaiting      <= 1'b0;
            r_pending_bcast <= 1'b0;
        end else begin
            if (accept) begin
                if (i_in_data.mode) begin
                    r_awaiting <= 1'b0;
                end else if (r_parse_count == PARSE_HUNT) begin
                    if (i_in_data.rx_byte == START_BYTE) begin
                        r_parse_count <= 3'd1;
                        r_sum         <= '0;
                    end
                end else if (r_parse_count != PARSE_CHECK) begin
                    r_frame[frame_idx] <= i_in_data.rx_byte;
                    r_sum              <= r_sum + i_in_data.rx_byte;
                    r_parse_count      <= r_parse_count + 3'd1;
                end else begin
                    r_parse_count <= PARSE_HUNT;
                    if (frame_ok) begin
                        if (r_frame[1] == CMD_SET_ID) begin
                            r_current_id <= r_frame[2];
                        end else if (r_frame[1] != CMD_ECHO) begin
                            r_awaiting      <= 1'b1;
                            r_pending_cmd   <= r_frame[1];
                            r_pending_bcast <= bcast;
                        end
                    end
                end
            end
            if (i_cfg_wr_en && i_cfg_index == REG_INITIAL_ID) begin
                r_current_id <= i_cfg_wdata;
            end
        end
    end

endmodule
`default_nettype wire

// File: rtl/assr_queue.sv
`default_nettype none
module assr_queue
    import assr_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_job i_job,
    output logic      o_full,
    output logic      o_valid,
    input  wire logic i_pop,
    output t_job      o_job
);

    t_job                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr;
    logic [QUEUE_AW-1:0] r_rd_ptr;
    logic [QUEUE_AW:0]   r_count;

    logic do_pop;

    assign o_full  = (r_count == (QUEUE_AW + 1)'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd_ptr];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && do_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

// File: rtl/assr_back.sv
`default_nettype none
module assr_back
    import assr_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_q_valid,
    input  wire t_job i_q_job,
    output logic      o_q_pop,
    input  wire logic i_rs485_dir,
    output logic      o_out_valid,
    input  wire logic i_out_ready,
    output t_out      o_out_data
);

    logic       r_active;
    t_job       r_job;
    logic [2:0] r_beat;

    logic       last_beat;
    logic       done;
    logic [7:0] sum;
    logic [7:0] tx;

    assign last_beat   = r_job.is_request || (r_beat == BEAT_LAST);
    assign done        = r_active && i_out_ready && last_beat;
    assign o_q_pop     = i_q_valid && (!r_active || done);
    assign o_out_valid = r_active;
    assign sum = r_job.id + r_job.cmd + r_job.data[7:0] + r_job.data[15:8];

    always_comb begin
        unique case (r_beat)
            3'd0:    tx = FILL_BYTE;
            3'd1:    tx = START_BYTE;
            3'd2:    tx = r_job.id;
            3'd3:    tx = r_job.cmd;
            3'd4:    tx = r_job.data[7:0];
            3'd5:    tx = r_job.data[15:8];
            3'd6:    tx = sum;
            default: tx = FILL_BYTE;
        endcase
    end

    always_comb begin
        if (r_job.is_request) begin
            o_out_data = '{kind: 1'b1, tx_byte: 8'd0, driver_enable: 1'b0, last: 1'b0,
                           request_cmd: r_job.cmd, request_data: r_job.data};
        end else begin
            o_out_data = '{kind: 1'b0, tx_byte: tx, driver_enable: i_rs485_dir,
                           last: (r_beat == BEAT_LAST), request_cmd: 8'd0,
                           request_data: 16'd0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_beat   <= '0;
        end else if (o_q_pop) begin
            r_active <= 1'b1;
            r_job    <= i_q_job;
            r_beat   <= '0;
        end else if (done) begin
            r_active <= 1'b0;
        end else if (r_active && i_out_ready) begin
            r_beat <= r_beat + 3'd1;
        end
    end

endmodule
`default_nettype wire

// File: rtl/addressed_serial_slave_responder.sv
`default_nettype none
// Channel  Direction  Handshake                  Payload
// in       input      i_in_valid / o_in_ready    i_in_data  (t_in)
// out      output     o_out_valid / i_out_ready  o_out_data (t_out)
// cfg      input      i_cfg_wr_en                i_cfg_index, i_cfg_wdata
//
// Every input beat is taken in one cycle while the job queue has room.
// A reply is 8 output beats, one per ready cycle; a handler request is one beat.
// The output serializer paces the block; the four-entry job queue absorbs bursts.
// Synchronous active-low reset clears the parser, the queue and the serializer.
// Output stalls hold the current beat; input stalls only once the queue fills.
module addressed_serial_slave_responder
    import assr_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire t_in        i_in_data,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output t_out            o_out_data,
    input  wire logic       i_cfg_wr_en,
    input  wire logic       i_cfg_index,
    input  wire logic [7:0] i_cfg_wdata
);

    logic      r_rs485_dir;
    logic      q_push;
    logic      q_full;
    t_job      push_job;
    t_job      head_job;
    logic      head_valid;
    logic      pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rs485_dir <= 1'b1;
        end else if (i_cfg_wr_en && i_cfg_index == REG_RS485_DIR) begin
            r_rs485_dir <= i_cfg_wdata[0];
        end
    end

    assr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_q_full    (q_full),
        .o_q_push    (q_push),
        .o_q_job     (push_job)
    );

    assr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (push_job),
        .o_full  (q_full),
        .o_valid (head_valid),
        .i_pop   (pop),
        .o_job   (head_job)
    );

    assr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (head_valid),
        .i_q_job     (head_job),
        .o_q_pop     (pop),
        .i_rs485_dir (r_rs485_dir),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule
`default_nettype wire

// File: test/assr_reply_monitor.sv
`timescale 1ns / 1ps

package assr_bench_pkg;

    localparam logic MODE_LINE    = 1'b0;
    localparam logic MODE_HANDLER = 1'b1;

    localparam logic KIND_BYTE    = 1'b0;
    localparam logic KIND_REQUEST = 1'b1;

endpackage

module assr_reply_monitor
    import assr_pkg::*;
    import assr_bench_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  t_in        i_in_data,
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  t_out       i_out_data,
    input  logic       i_cfg_wr_en,
    input  logic       i_cfg_index,
    input  logic [7:0] i_cfg_wdata,
    output int         o_fail_count,
    output int         o_outstanding
);

    logic [2:0]  parse_pos;
    logic [7:0]  frame_byte [4];
    logic [7:0]  sum_acc;
    logic [7:0]  my_id;
    logic        handler_busy;
    logic [7:0]  held_cmd;
    logic [15:0] held_data;
    logic        held_bcast;
    logic        drive_en;

    t_out due_beats[$];
    int   fail_count = 0;

    task automatic queue_reply(input logic [7:0] cmd, input logic [15:0] data);
        logic [7:0] seq [8];
        t_out       beat;
        seq[0] = FILL_BYTE;
        seq[1] = START_BYTE;
        seq[2] = my_id;
        seq[3] = cmd;
        seq[4] = data[7:0];
        seq[5] = data[15:8];
        seq[6] = my_id + cmd + data[7:0] + data[15:8];
        seq[7] = FILL_BYTE;
        for (int i = 0; i < 8; i++) begin
            beat = '0;
            beat.kind = KIND_BYTE;
            beat.tx_byte = seq[i];
            beat.driver_enable = drive_en;
            beat.last = (i == 7);
            due_beats.push_back(beat);
        end
    endtask

    task automatic close_frame();
        logic [7:0]  id;
        logic [7:0]  cmd;
        logic [15:0] data;
        logic        bcast;
        t_out        req;
        id = frame_byte[0];
        cmd = frame_byte[1];
        data = {frame_byte[3], frame_byte[2]};
        // A frame that lands while a handler reply is owed is dropped outright.
        if (handler_busy)
            return;
        if (id == BROADCAST_ID)
            bcast = 1'b1;
        else if (id == my_id)
            bcast = 1'b0;
        else
            return;
        if (cmd == CMD_ECHO) begin
            if (!bcast)
                queue_reply(cmd, data);
        end else if (cmd == CMD_SET_ID) begin
            my_id = frame_byte[2];
            if (!bcast)
                queue_reply(cmd, data);
        end else begin
            handler_busy = 1'b1;
            held_cmd = cmd;
            held_data = data;
            held_bcast = bcast;
            req = '0;
            req.kind = KIND_REQUEST;
            req.request_cmd = cmd;
            req.request_data = data;
            due_beats.push_back(req);
        end
    endtask

    task automatic take_line_byte(input logic [7:0] b);
        if (parse_pos == PARSE_HUNT) begin
            if (b == START_BYTE) begin
                parse_pos = 3'd1;
                sum_acc = 8'd0;
            end
        end else if (parse_pos < PARSE_CHECK) begin
            frame_byte[2'(parse_pos - 3'd1)] = b;
            sum_acc = sum_acc + b;
            parse_pos = parse_pos + 3'd1;
        end else begin
            parse_pos = PARSE_HUNT;
            if (b == sum_acc)
                close_frame();
        end
    endtask

    task automatic take_handler_reply(input logic accept, input logic [15:0] data);
        if (!handler_busy)
            return;
        handler_busy = 1'b0;
        if (accept && !held_bcast)
            queue_reply(held_cmd, data);
    endtask

    function automatic bit field_ok(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            return 1'b0;
        end
        return 1'b1;
    endfunction

    always @(posedge i_clk) begin
        t_out want;
        bit   ok;
        if (!i_rst_n) begin
            parse_pos = PARSE_HUNT;
            sum_acc = 8'd0;
            my_id = 8'd0;
            handler_busy = 1'b0;
            held_cmd = 8'd0;
            held_data = 16'd0;
            held_bcast = 1'b0;
            drive_en = 1'b1;
            for (int i = 0; i < 4; i++)
                frame_byte[i] = 8'd0;
            due_beats.delete();
        end else begin
            if (i_cfg_wr_en) begin
                if (i_cfg_index == REG_INITIAL_ID)
                    my_id = i_cfg_wdata;
                else
                    drive_en = i_cfg_wdata[0];
            end
            if (i_in_valid && i_in_ready) begin
                if (i_in_data.mode == MODE_HANDLER)
                    take_handler_reply(i_in_data.handler_accept, i_in_data.handler_data);
                else
                    take_line_byte(i_in_data.rx_byte);
            end
            if (i_out_valid && i_out_ready) begin
                if (due_beats.size() == 0) begin
                    $error("unexpected output beat: kind %0d tx_byte 0x%0h",
                           i_out_data.kind, i_out_data.tx_byte);
                    fail_count++;
                end else begin
                    want = due_beats.pop_front();
                    ok = field_ok("kind", want.kind, i_out_data.kind)
                       & field_ok("tx_byte", want.tx_byte, i_out_data.tx_byte)
                       & field_ok("driver_enable", want.driver_enable,
                                  i_out_data.driver_enable)
                       & field_ok("last", want.last, i_out_data.last)
                       & field_ok("request_cmd", want.request_cmd, i_out_data.request_cmd)
                       & field_ok("request_data", want.request_data,
                                  i_out_data.request_data);
                    if (!ok)
                        fail_count++;
                end
            end
        end
        o_fail_count <= fail_count;
        o_outstanding <= due_beats.size();
    end

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps

module tb;
    import assr_pkg::*;
    import assr_bench_pkg::*;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    t_in        in_data = '0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    t_out       out_data;
    logic       cfg_wr_en = 1'b0;
    logic       cfg_index = REG_INITIAL_ID;
    logic [7:0] cfg_wdata = 8'd0;

    int fail_count;
    int outstanding;

    int idle_pct = 0;
    int stall_pct = 0;

    // Stimulus-side view of the slave, used to aim frames at it and to time handler replies.
    logic [7:0] slave_id = 8'd0;
    logic       waiting = 1'b0;

    always #4 clk = ~clk;

    addressed_serial_slave_responder dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_wr_en (cfg_wr_en),
        .i_cfg_index (cfg_index),
        .i_cfg_wdata (cfg_wdata)
    );

    assr_reply_monitor monitor (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_ready    (in_ready),
        .i_in_data     (in_data),
        .i_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .i_out_data    (out_data),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_index   (cfg_index),
        .i_cfg_wdata   (cfg_wdata),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    always @(posedge clk) begin
        out_ready <= ($urandom_range(99) >= stall_pct);
    end

    function automatic t_in line_beat(input logic [7:0] b);
        t_in beat;
        beat.mode = MODE_LINE;
        beat.rx_byte = b;
        beat.handler_accept = 1'($urandom_range(1));
        beat.handler_data = 16'($urandom_range(65535));
        return beat;
    endfunction

    function automatic t_in handler_beat(input logic accept, input logic [15:0] data);
        t_in beat;
        beat.mode = MODE_HANDLER;
        beat.rx_byte = 8'($urandom_range(255));
        beat.handler_accept = accept;
        beat.handler_data = data;
        return beat;
    endfunction

    task automatic push_item(input t_in item);
        while ($urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= item;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic send_frame(input logic [7:0] id, input logic [7:0] cmd,
                              input logic [7:0] lo, input logic [7:0] hi,
                              input logic bad);
        logic [7:0] chk;
        chk = id + cmd + lo + hi;
        if (bad)
            chk = chk ^ 8'($urandom_range(1, 255));
        push_item(line_beat(START_BYTE));
        push_item(line_beat(id));
        push_item(line_beat(cmd));
        push_item(line_beat(lo));
        push_item(line_beat(hi));
        push_item(line_beat(chk));
        if (!bad && !waiting && (id == BROADCAST_ID || id == slave_id)) begin
            if (cmd == CMD_SET_ID)
                slave_id = lo;
            else if (cmd != CMD_ECHO)
                waiting = 1'b1;
        end
    endtask

    task automatic send_reply(input logic accept, input logic [15:0] data);
        push_item(handler_beat(accept, data));
        waiting = 1'b0;
    endtask

    // Drop valid and hold off until every predicted beat has left the block.
    task automatic quiesce();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (24) @(posedge clk);
    endtask

    task automatic configure(input logic [7:0] id, input logic dir);
        quiesce();
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_INITIAL_ID;
        cfg_wdata <= id;
        @(posedge clk);
        cfg_index <= REG_RS485_DIR;
        cfg_wdata <= {7'd0, dir};
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        slave_id = id;
    endtask

    task automatic random_frame();
        logic [7:0] id;
        logic [7:0] cmd;
        int         pick;
        pick = $urandom_range(9);
        if (pick < 6)
            id = slave_id;
        else if (pick < 8)
            id = BROADCAST_ID;
        else
            id = 8'($urandom_range(255));
        pick = $urandom_range(19);
        if (pick < 6)
            cmd = CMD_ECHO;
        else if (pick < 9)
            cmd = CMD_SET_ID;
        else
            cmd = 8'($urandom_range(255));
        send_frame(id, cmd, 8'($urandom_range(255)), 8'($urandom_range(255)),
                   $urandom_range(9) == 0);
    endtask

    initial begin
        int         idle_tab [4] = '{0, 63, 0, 12};
        int         stall_tab [4] = '{0, 0, 63, 12};
        logic [7:0] id_tab [4] = '{8'h5A, 8'hFF, 8'h00, 8'h81};
        logic       dir_tab [4] = '{1'b1, 1'b0, 1'b1, 1'b0};
        int         sent;
        int         pick;
        logic [7:0] noise;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        configure(8'h00, 1'b1);
        // Stray handler reply, idle noise, echo of full-scale data, an id change
        // to the start byte value, then the highest command through the handler.
        push_item(handler_beat(1'b1, 16'hFFFF));
        push_item(line_beat(8'h00));
        send_frame(8'h00, CMD_ECHO, 8'hFF, 8'hFF, 1'b0);
        send_frame(8'h00, CMD_SET_ID, START_BYTE, 8'h00, 1'b0);
        send_frame(START_BYTE, 8'd255, 8'h34, 8'h12, 1'b0);
        send_reply(1'b1, 16'hFFFF);

        for (int ph = 0; ph < 4; ph++) begin
            configure(id_tab[ph], dir_tab[ph]);
            idle_pct = idle_tab[ph];
            stall_pct = stall_tab[ph];
            sent = 0;
            while (sent < 68) begin
                pick = $urandom_range(99);
                if (waiting && pick < 80) begin
                    send_reply($urandom_range(3) != 0, 16'($urandom_range(65535)));
                    sent++;
                    if ($urandom_range(15) == 0)
                        quiesce();
                end else if (pick < 15) begin
                    if ($urandom_range(2) == 0) begin
                        push_item(handler_beat(1'($urandom_range(1)),
                                               16'($urandom_range(65535))));
                    end else begin
                        noise = 8'($urandom_range(255));
                        if (noise == START_BYTE && $urandom_range(7) != 0)
                            noise = 8'h00;
                        push_item(line_beat(noise));
                    end
                    sent++;
                end else begin
                    random_frame();
                    sent += 6;
                end
            end
        end

        quiesce();
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial begin
        #4000000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

// File: addressed_serial_slave_responder.f
rtl/assr_pkg.sv
rtl/assr_front.sv
rtl/assr_queue.sv
rtl/assr_back.sv
rtl/addressed_serial_slave_responder.sv
test/assr_reply_monitor.sv
test/tb.sv
